@@ hw/rtl/lpht_pkg.sv @@
// Package for the linear-probing hash table: sizes, status codes, sequencer states, helpers.
package lpht_pkg;

  localparam int TABLE_SLOTS  = 16;
  localparam int SLOT_W       = $clog2(TABLE_SLOTS);
  localparam int KEY_W        = 31;
  localparam int REC_W        = 32;
  localparam int STATUS_W     = 2;
  localparam int SLOT_FIELD_W = 4;
  localparam int DIGIT_W      = 4;
  localparam int DIGITS       = (KEY_W + DIGIT_W) / DIGIT_W;
  localparam int DIG_W        = $clog2(DIGITS);
  localparam int KEY_PAD_W    = DIGITS * DIGIT_W;
  localparam bit IS_POW2      = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_SLOTS - 1);
  localparam logic [DIG_W-1:0]  DIG_LAST  = DIG_W'(DIGITS - 1);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_FETCH,
    S_PROBE,
    S_FINISH
  } state_t;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == SLOT_LAST) ? '0 : s + 1'b1;
  endfunction

  // Fold one key digit into the running remainder, one bit per step.
  function automatic logic [SLOT_W-1:0] rem_step(input logic [SLOT_W-1:0] r_in,
                                                 input logic [DIGIT_W-1:0] d);
    logic [SLOT_W:0]   t;
    logic [SLOT_W-1:0] r;
    r = r_in;
    for (int i = DIGIT_W - 1; i >= 0; i--) begin
      t = {r, d[i]};
      if (t >= (SLOT_W + 1)'(TABLE_SLOTS)) begin
        t = t - (SLOT_W + 1)'(TABLE_SLOTS);
      end
      r = t[SLOT_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [SLOT_FIELD_W-1:0] slot_field(input logic [SLOT_W-1:0] s);
    logic [31:0] wide;
    wide = 32'(s);
    return wide[SLOT_FIELD_W-1:0];
  endfunction

endpackage

@@ hw/rtl/linear_probe_hash_table.sv @@
// Linear-probing hash table: insert and search over one shared probe/compare sequencer.
//
//   channel  direction  handshake            payload
//   in       receive    in_valid/in_stall    opcode, lookup_key, record_data
//   out      send       out_valid/out_stall  status, slot_index, found_record
//
// An item is hashed in S_HASH, from its low key bits when TABLE_SLOTS is a power of
// two, else by folding its DIGITS four-bit digits into a remainder; S_FETCH reads its
// first slot, then S_PROBE checks 1 to TABLE_SLOTS slots, set by one table read per
// cycle, then S_FINISH posts the result and S_IDLE takes the next transfer.
// After reset the occupied flags are cleared one slot a cycle, slot 0 to SLOT_LAST,
// with in_stall high. in_stall is high whenever an item is at work; a result held
// by out_stall holds the next result in S_FINISH, and with it the next transfer.
module linear_probe_hash_table (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                opcode,
  input  logic [lpht_pkg::KEY_W-1:0]          lookup_key,
  input  logic [lpht_pkg::REC_W-1:0]          record_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [lpht_pkg::STATUS_W-1:0]       status,
  output logic [lpht_pkg::SLOT_FIELD_W-1:0]   slot_index,
  output logic [lpht_pkg::REC_W-1:0]          found_record
);
  import lpht_pkg::*;

  state_t state, state_next;

  logic [SLOT_W-1:0]   slot;
  logic [SLOT_W-1:0]   cnt;
  logic [DIG_W-1:0]    dig;
  logic [SLOT_W-1:0]   rem;
  logic                op_r;
  logic [KEY_W-1:0]    key_r;
  logic [REC_W-1:0]    rec_r;

  logic [STATUS_W-1:0]     pend_status;
  logic [SLOT_FIELD_W-1:0] pend_slot;
  logic [REC_W-1:0]        pend_rec;

  logic                occ_mem [TABLE_SLOTS];
  logic [KEY_W-1:0]    key_mem [TABLE_SLOTS];
  logic [REC_W-1:0]    rec_mem [TABLE_SLOTS];
  logic                occ_q;
  logic [KEY_W-1:0]    key_q;
  logic [REC_W-1:0]    rec_q;

  logic [SLOT_W-1:0]   rd_addr;
  logic                occ_we;
  logic                occ_wd;
  logic                ent_we;

  logic                accept;
  logic                last_probe;
  logic                probe_done;
  logic                post;
  logic [KEY_PAD_W-1:0] key_pad;
  logic [DIG_W-1:0]    dig_idx;
  logic [SLOT_W-1:0]   rem_next;

  assign accept     = in_valid && !in_stall;
  assign last_probe = (cnt == SLOT_LAST);
  assign key_pad    = KEY_PAD_W'(key_r);
  assign dig_idx    = DIG_LAST - dig;
  assign rem_next   = rem_step(rem, key_pad[{dig_idx, 2'b00} +: DIGIT_W]);
  assign post       = !out_valid || !out_stall;

  always_comb begin
    if (op_r == OP_INSERT) begin
      probe_done = !occ_q || last_probe;
    end else begin
      probe_done = !occ_q || (key_q == key_r) || last_probe;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:  if (slot == SLOT_LAST) state_next = S_IDLE;
      S_IDLE:   if (in_valid) state_next = S_HASH;
      S_HASH:   if (IS_POW2 || dig == DIG_LAST) state_next = S_FETCH;
      S_FETCH:  state_next = S_PROBE;
      S_PROBE:  if (probe_done) state_next = S_FINISH;
      S_FINISH: if (post) state_next = S_IDLE;
      default:  state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    rd_addr  = slot;
    occ_we   = 1'b0;
    occ_wd   = 1'b0;
    ent_we   = 1'b0;
    case (state)
      S_CLEAR: begin
        occ_we = 1'b1;
      end
      S_IDLE: begin
        in_stall = 1'b0;
      end
      S_PROBE: begin
        rd_addr = next_slot(slot);
        if (op_r == OP_INSERT && !occ_q) begin
          occ_we = 1'b1;
          occ_wd = 1'b1;
          ent_we = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (occ_we) occ_mem[slot] <= occ_wd;
    if (ent_we) begin
      key_mem[slot] <= key_r;
      rec_mem[slot] <= rec_r;
    end
    occ_q <= occ_mem[rd_addr];
    key_q <= key_mem[rd_addr];
    rec_q <= rec_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
    end else begin
      case (state)
        S_CLEAR: slot <= next_slot(slot);
        S_HASH:  begin
          if (IS_POW2) begin
            slot <= key_r[SLOT_W-1:0];
          end else if (dig == DIG_LAST) begin
            slot <= rem_next;
          end
        end
        S_PROBE: if (!probe_done) slot <= next_slot(slot);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= opcode;
      key_r <= lookup_key;
      rec_r <= record_data;
      dig   <= '0;
      rem   <= '0;
    end
    if (state == S_HASH) begin
      dig <= dig + 1'b1;
      rem <= rem_next;
    end
    if (state == S_FETCH) cnt <= '0;
    if (state == S_PROBE) begin
      cnt <= cnt + 1'b1;
      if (op_r == OP_INSERT) begin
        pend_rec <= '0;
        if (!occ_q) begin
          pend_status <= ST_INSERTED;
          pend_slot   <= slot_field(slot);
        end else begin
          pend_status <= ST_FULL;
          pend_slot   <= '0;
        end
      end else if (occ_q && key_q == key_r) begin
        pend_status <= ST_FOUND;
        pend_slot   <= slot_field(slot);
        pend_rec    <= rec_q;
      end else begin
        pend_status <= ST_NOT_FOUND;
        pend_slot   <= '0;
        pend_rec    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FINISH && post) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && post) begin
      status       <= pend_status;
      slot_index   <= pend_slot;
      found_record <= pend_rec;
    end
  end

  a_accept_starts_hash: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_HASH)
    else $error("accepted item did not start hashing");

  a_record_only_on_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_FOUND |-> found_record == '0)
    else $error("record word posted without a hit");

  a_slot_zero_on_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL || status == ST_NOT_FOUND) |-> slot_index == '0)
    else $error("slot index posted on miss or full");

  a_write_only_on_insert: assert property (@(posedge clk) disable iff (rst)
    ent_we |-> op_r == OP_INSERT && state == S_PROBE && !occ_q)
    else $error("table entry written outside an insert into a free slot");

endmodule
